FILE: hdl/rbd_pkg.sv
// Package for the ring buffer deque: sizes, command codes and reset values.
// No dependencies; used by ring_buffer_deque.
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CAP_W     = $clog2(MAX_SLOTS + 1);
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(MAX_SLOTS);
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_PEEK      = 3'd4
  } cmd_t;

endpackage

FILE: hdl/ring_buffer_deque.sv
// Double-ended queue held in a 16-entry ring memory with front/rear pointers.
// Depends on rbd_pkg for sizes, command codes and reset values.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake             | Payload
//  in_     | input     | in_tvalid / in_tready | tuser: command, tdata: data_value
//  out_    | output    | out_tvalid/out_tready | tdata: succeeded, front, rear, flags
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_data: capacity_in_use
//
// The accepting edge updates the pointers, writes the memory and launches the two
// memory reads; in the cycle after, the result register is loaded from the
// registered read data, since the memory reads are registered.
// A new command is taken while the previous result is being handed off.
// Reset (synchronous, active low) empties the deque and sets the capacity to 16.
// A stalled output holds its result and blocks the input until it is taken.

module ring_buffer_deque (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] command
  input  logic [31:0] in_tdata,   // [31:0] data_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [0] succeeded, [32:1] front_value,
                                  // [64:33] rear_value, [65] now_empty,
                                  // [66] now_full, [71:67] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // [4:0] capacity_in_use
);

  localparam int IW = rbd_pkg::IDX_W;
  localparam int CW = rbd_pkg::CAP_W;
  localparam int DW = rbd_pkg::DATA_W;

  function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i,
                                            input logic [CW-1:0] cap);
    logic [CW-1:0] nx;
    nx = CW'(i) + CW'(1);
    return (nx >= cap) ? '0 : nx[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i,
                                              input logic [CW-1:0] cap);
    logic [CW-1:0] pv;
    pv = cap - CW'(1);
    return (i == '0) ? pv[IW-1:0] : i - IW'(1);
  endfunction

  // Ring memory, one write port and two registered read ports.
  logic [DW-1:0] ring_mem [rbd_pkg::MAX_SLOTS];

  logic [CW-1:0] cap_r;
  logic [IW-1:0] front_r, front_nxt;
  logic [IW-1:0] rear_r, rear_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic          rd_pend_r;

  logic [CW-1:0] cap_eff;
  logic [IW-1:0] f_n, r_n, rd_rear_addr;
  logic          is_full, is_empty, ok;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          in_fire, out_fire;

  // Read data and forwarding information for the result stage.
  logic [DW-1:0] rd_front_r, rd_rear_r, wdata_r;
  logic          fwd_front_r, fwd_rear_r;
  logic          ok_r, empty_r, full_r;

  // Result register.
  logic          out_valid_r;
  logic          res_ok_r, res_empty_r, res_full_r;
  logic [DW-1:0] res_front_r, res_rear_r;

  // Nothing is taken while reset is held.
  assign cfg_ready = rst_n;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;
  assign in_tready = rst_n && !rd_pend_r && (!out_valid_r || out_tready);

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_r > rbd_pkg::CAP_RESET) begin
      cap_eff = rbd_pkg::CAP_RESET;
    end else begin
      cap_eff = cap_r;
    end
  end

  always_comb begin
    f_n       = (CW'(front_r) >= cap_eff) ? '0 : front_r;
    r_n       = (CW'(rear_r) >= cap_eff) ? '0 : rear_r;
    is_full   = occ_r >= cap_eff;
    is_empty  = occ_r == '0;
    front_nxt = f_n;
    rear_nxt  = r_n;
    occ_nxt   = occ_r;
    ok        = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = r_n;
    unique case (in_tuser)
      rbd_pkg::CMD_INS_FRONT: begin
        if (!is_full) begin
          front_nxt = step_down(f_n, cap_eff);
          wr_addr   = front_nxt;
          wr_en     = 1'b1;
          occ_nxt   = occ_r + CW'(1);
          ok        = 1'b1;
        end
      end
      rbd_pkg::CMD_INS_REAR: begin
        if (!is_full) begin
          wr_addr  = r_n;
          wr_en    = 1'b1;
          rear_nxt = step_up(r_n, cap_eff);
          occ_nxt  = occ_r + CW'(1);
          ok       = 1'b1;
        end
      end
      rbd_pkg::CMD_DEL_FRONT: begin
        if (!is_empty) begin
          front_nxt = step_up(f_n, cap_eff);
          occ_nxt   = occ_r - CW'(1);
          ok        = 1'b1;
        end
      end
      rbd_pkg::CMD_DEL_REAR: begin
        if (!is_empty) begin
          rear_nxt = step_down(r_n, cap_eff);
          occ_nxt  = occ_r - CW'(1);
          ok       = 1'b1;
        end
      end
      rbd_pkg::CMD_PEEK: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    rd_rear_addr = step_down(rear_nxt, cap_eff);
  end

  // Memory: the reads return the old contents, so a write to the same slot
  // in the same cycle is forwarded from wdata_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (wr_en) begin
        ring_mem[wr_addr] <= in_tdata;
      end
      rd_front_r  <= ring_mem[front_nxt];
      rd_rear_r   <= ring_mem[rd_rear_addr];
      wdata_r     <= in_tdata;
      fwd_front_r <= wr_en && (wr_addr == front_nxt);
      fwd_rear_r  <= wr_en && (wr_addr == rd_rear_addr);
      ok_r        <= ok;
      empty_r     <= occ_nxt == '0;
      full_r      <= occ_nxt >= cap_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= rbd_pkg::CAP_RESET;
      front_r   <= '0;
      rear_r    <= '0;
      occ_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= in_fire;
      if (cfg_valid && cfg_ready) begin
        cap_r   <= cfg_data;
        front_r <= '0;
        rear_r  <= '0;
        occ_r   <= '0;
      end else if (in_fire) begin
        front_r <= front_nxt;
        rear_r  <= rear_nxt;
        occ_r   <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      res_ok_r    <= ok_r;
      res_empty_r <= empty_r;
      res_full_r  <= full_r;
      if (empty_r) begin
        res_front_r <= rbd_pkg::EMPTY_VALUE;
        res_rear_r  <= rbd_pkg::EMPTY_VALUE;
      end else begin
        res_front_r <= fwd_front_r ? wdata_r : rd_front_r;
        res_rear_r  <= fwd_rear_r ? wdata_r : rd_rear_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_full_r, res_empty_r, res_rear_r, res_front_r, res_ok_r};

  // The pipeline is sequential: a pending read always turns into a result next cycle.
  a_pend_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r)
    else $error("pending read did not produce a result");

  // No new transaction while a read is still in flight.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_fire)
    else $error("two commands accepted back to back");

  // Occupancy stays within the ring.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= rbd_pkg::CAP_RESET)
    else $error("occupancy exceeds ring size");

  // An empty result reports all-ones for both ends.
  a_empty_vals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_empty_r) |-> (res_front_r == rbd_pkg::EMPTY_VALUE
                                      && res_rear_r == rbd_pkg::EMPTY_VALUE))
    else $error("empty result carries data");

endmodule
